// ----- src/imhq_pkg.sv -----
package imhq_pkg;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_RAISE  = 3'd1,
        CMD_LOWER  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         id;
        logic signed [31:0] priority_req;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [5:0]         id_out;
        logic signed [31:0] priority_out;
        logic [6:0]         count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ID,
        ST_DECIDE,
        ST_RM_RD,
        ST_RM_WAIT,
        ST_RM_PRI,
        ST_UP_RD,
        ST_UP_PID,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_LP,
        ST_DN_RP,
        ST_OUT
    } t_state;
endpackage

// ----- src/imhq_ram.sv -----
module imhq_ram import imhq_pkg::*; #(
    parameter int W = 32,
    parameter int D = CAPACITY_DEF,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/indexed_max_heap_queue.sv -----
// channel  | valid    | ready    | payload
// request  | i_valid  | o_ready  | i_req   (t_req)
// result   | o_valid  | i_ready  | o_rsp   (t_rsp)
// one request at a time: a query or a reject finishes after the decide step; an insert
// or raise sifts up and a lower or remove sifts down, level by level, through the
// slot, position and priority memories, whose reads are registered.
// reset clears the valid marks and the count at once; no clearing pass.
// a finished result holds in the output register; o_ready returns the cycle after
// it is taken.
module indexed_max_heap_queue import imhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    t_state r_st, n_st;
    t_req   r_req;
    logic [CAPACITY-1:0] r_vld;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_pos;
    logic signed [31:0] r_wpri, r_lpri;
    logic [5:0] r_who, r_lid, r_rid;
    t_rsp r_rsp;
    logic r_ov;

    // slot -> id
    logic          s_we;  logic [AW-1:0] s_wa, s_ra; logic [5:0] s_wd, s_rd;
    // id -> position
    logic          p_we;  logic [AW-1:0] p_wa, p_ra; logic [AW-1:0] p_wd, p_rd;
    // id -> priority
    logic          q_we;  logic [AW-1:0] q_wa, q_ra; logic [31:0] q_wd, q_rd;

    imhq_ram #(.W(6),  .D(CAPACITY)) u_slot
        (.i_clk, .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
         .i_raddr(s_ra), .o_rdata(s_rd));
    imhq_ram #(.W(AW), .D(CAPACITY)) u_pos
        (.i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
         .i_raddr(p_ra), .o_rdata(p_rd));
    imhq_ram #(.W(32), .D(CAPACITY)) u_pri
        (.i_clk, .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
         .i_raddr(q_ra), .o_rdata(q_rd));

    logic id_ok, present;
    logic [AW-1:0] id_a, who_a, up_a;
    logic [CW-1:0] l_c, r_c;
    logic signed [31:0] qs, req_pri;

    assign id_ok   = {26'd0, r_req.id} < 32'(CAPACITY);
    assign id_a    = AW'(r_req.id);
    assign who_a   = AW'(r_who);
    assign present = id_ok && r_vld[id_a];
    assign up_a    = (r_pos - AW'(1)) >> 1;
    assign l_c     = {r_pos, 1'b1};
    assign r_c     = l_c + 1'b1;
    assign qs      = $signed(q_rd);
    assign req_pri = $signed(r_req.priority_req);

    t_rsp n_rsp;
    logic n_ov;
    logic [CW-1:0] n_cnt;
    logic [AW-1:0] n_pos;
    logic signed [31:0] n_wpri, n_lpri;
    logic [5:0] n_who, n_lid, n_rid;
    logic v_set, v_clr;
    logic [AW-1:0] v_a;

    assign o_ready = (r_st == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_st = r_st; n_rsp = r_rsp; n_ov = r_ov;
        n_cnt = r_cnt; n_pos = r_pos;
        n_wpri = r_wpri; n_lpri = r_lpri;
        n_who = r_who; n_lid = r_lid; n_rid = r_rid;
        v_set = 1'b0; v_clr = 1'b0; v_a = id_a;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = id_a;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = id_a;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            ST_IDLE: if (i_valid && o_ready) n_st = ST_RD_ID;
            ST_RD_ID: begin
                q_ra = id_a; p_ra = id_a; s_ra = '0;
                n_st = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_rsp = '{ok: 1'b0, id_out: r_req.id, priority_out: '0, count: 7'(r_cnt)};
                n_st = ST_OUT;
                unique case (r_req.cmd)
                    CMD_INSERT: if (id_ok && !present && r_cnt < CW'(CAPACITY)) begin
                        v_set = 1'b1;
                        q_we = 1'b1; q_wa = id_a; q_wd = r_req.priority_req;
                        n_who = r_req.id; n_wpri = req_pri;
                        n_pos = AW'(r_cnt); n_cnt = r_cnt + 1'b1;
                        n_rsp.ok = 1'b1; n_rsp.count = 7'(r_cnt + 1'b1);
                        n_st = ST_UP_RD;
                    end
                    CMD_RAISE: if (present && qs < req_pri) begin
                        q_we = 1'b1; q_wa = id_a; q_wd = r_req.priority_req;
                        n_who = r_req.id; n_wpri = req_pri; n_pos = p_rd;
                        n_rsp.ok = 1'b1; n_st = ST_UP_RD;
                    end
                    CMD_LOWER: if (present && qs > req_pri) begin
                        q_we = 1'b1; q_wa = id_a; q_wd = r_req.priority_req;
                        n_who = r_req.id; n_wpri = req_pri; n_pos = p_rd;
                        n_rsp.ok = 1'b1; n_st = ST_DN_RDL;
                    end
                    CMD_REMOVE: if (r_cnt != '0) begin
                        n_who = s_rd; n_cnt = r_cnt - 1'b1;
                        v_clr = 1'b1; v_a = AW'(s_rd);
                        n_rsp.ok = 1'b1; n_rsp.id_out = s_rd;
                        n_rsp.count = 7'(r_cnt - 1'b1);
                        n_st = ST_RM_RD;
                    end
                    CMD_QUERY: if (present) begin
                        n_rsp.ok = 1'b1; n_rsp.priority_out = qs;
                    end
                    default: ;
                endcase
            end
            ST_RM_RD: begin
                q_ra = who_a; s_ra = AW'(r_cnt);
                n_st = ST_RM_WAIT;
            end
            ST_RM_WAIT: begin
                n_rsp.priority_out = qs;
                if (r_cnt != '0) begin
                    n_who = s_rd; n_pos = '0;
                    q_ra = AW'(s_rd);
                    n_st = ST_RM_PRI;
                end else begin
                    n_st = ST_OUT;
                end
            end
            ST_RM_PRI: begin
                n_wpri = qs;
                n_st = ST_DN_RDL;
            end
            ST_UP_RD: begin
                s_we = 1'b1; s_wa = r_pos; s_wd = r_who;
                p_we = 1'b1; p_wa = who_a; p_wd = r_pos;
                if (r_pos == '0) begin
                    n_st = ST_OUT;
                end else begin
                    s_ra = up_a; n_st = ST_UP_PID;
                end
            end
            ST_UP_PID: begin
                q_ra = AW'(s_rd); n_lid = s_rd;
                n_st = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (r_wpri > qs) begin
                    s_we = 1'b1; s_wa = r_pos; s_wd = r_lid;
                    p_we = 1'b1; p_wa = AW'(r_lid); p_wd = r_pos;
                    n_pos = up_a; n_st = ST_UP_RD;
                end else begin
                    n_st = ST_OUT;
                end
            end
            ST_DN_RDL: begin
                s_we = 1'b1; s_wa = r_pos; s_wd = r_who;
                p_we = 1'b1; p_wa = who_a; p_wd = r_pos;
                if (l_c >= r_cnt) begin
                    n_st = ST_OUT;
                end else begin
                    s_ra = AW'(l_c); n_st = ST_DN_RDR;
                end
            end
            ST_DN_RDR: begin
                q_ra = AW'(s_rd); n_lid = s_rd;
                s_ra = AW'(r_c);
                n_st = ST_DN_LP;
            end
            ST_DN_LP: begin
                n_lpri = qs;
                if (r_c < r_cnt) begin
                    q_ra = AW'(s_rd); n_rid = s_rd;
                    n_st = ST_DN_RP;
                end else if (r_wpri < qs) begin
                    s_we = 1'b1; s_wa = r_pos; s_wd = r_lid;
                    p_we = 1'b1; p_wa = AW'(r_lid); p_wd = r_pos;
                    n_pos = AW'(l_c); n_st = ST_DN_RDL;
                end else begin
                    n_st = ST_OUT;
                end
            end
            ST_DN_RP: begin
                n_st = ST_OUT;
                if (r_lpri > qs) begin
                    if (r_wpri < r_lpri) begin
                        s_we = 1'b1; s_wa = r_pos; s_wd = r_lid;
                        p_we = 1'b1; p_wa = AW'(r_lid); p_wd = r_pos;
                        n_pos = AW'(l_c); n_st = ST_DN_RDL;
                    end
                end else if (r_wpri < qs) begin
                    s_we = 1'b1; s_wa = r_pos; s_wd = r_rid;
                    p_we = 1'b1; p_wa = AW'(r_rid); p_wd = r_pos;
                    n_pos = AW'(r_c); n_st = ST_DN_RDL;
                end
            end
            ST_OUT: begin
                n_ov = 1'b1; n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0; r_cnt <= '0; r_vld <= '0;
        end else begin
            r_st <= n_st; r_ov <= n_ov; r_cnt <= n_cnt;
            if (v_set) r_vld[v_a] <= 1'b1;
            else if (v_clr) r_vld[v_a] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_req <= i_req;
        r_rsp <= n_rsp; r_pos <= n_pos;
        r_wpri <= n_wpri; r_lpri <= n_lpri;
        r_who <= n_who; r_lid <= n_lid; r_rid <= n_rid;
    end
endmodule

// ----- verif/heap_checker.sv -----
module heap_checker import imhq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_ready,
    input  t_req i_req,
    input  logic o_valid,
    input  logic i_ready,
    input  t_rsp o_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0]         slot_id [64];
    logic [5:0]         id_slot [64];
    logic signed [31:0] id_pri  [64];
    logic               id_live [64];
    int                 heap_count;
    t_rsp               rsp_queue [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = rsp_queue.size();

    function automatic void put(int slot, logic [5:0] who);
        slot_id[slot] = who;
        id_slot[who]  = slot[5:0];
    endfunction

    function automatic void bubble_up(logic [5:0] who);
        int pos;
        int up;
        logic [5:0] other;
        pos = id_slot[who];
        while (pos > 0) begin
            up = (pos - 1) / 2;
            other = slot_id[up];
            if (id_pri[who] <= id_pri[other]) break;
            put(pos, other);
            put(up, who);
            pos = up;
        end
    endfunction

    function automatic void bubble_down(logic [5:0] who);
        int pos;
        int l;
        int r;
        int cpos;
        logic [5:0] pick;
        pos = id_slot[who];
        forever begin
            l = pos * 2 + 1;
            r = l + 1;
            if (l >= heap_count) break;
            pick = slot_id[l];
            if (r < heap_count) begin
                if (!(id_pri[pick] > id_pri[slot_id[r]])) pick = slot_id[r];
            end
            if (!(id_pri[who] < id_pri[pick])) break;
            cpos = id_slot[pick];
            put(pos, pick);
            put(cpos, who);
            pos = cpos;
        end
    endfunction

    function automatic t_rsp apply_heap_op(t_req rq);
        t_rsp rs;
        logic present;
        logic [5:0] top;
        present = id_live[rq.id];
        rs.ok = 1'b0;
        rs.id_out = rq.id;
        rs.priority_out = '0;
        case (rq.cmd)
            CMD_INSERT: begin
                if (!present && heap_count < 64) begin
                    id_live[rq.id] = 1'b1;
                    id_pri[rq.id] = rq.priority_req;
                    put(heap_count, rq.id);
                    heap_count++;
                    bubble_up(rq.id);
                    rs.ok = 1'b1;
                end
            end
            CMD_RAISE: begin
                if (present && id_pri[rq.id] < rq.priority_req) begin
                    id_pri[rq.id] = rq.priority_req;
                    bubble_up(rq.id);
                    rs.ok = 1'b1;
                end
            end
            CMD_LOWER: begin
                if (present && id_pri[rq.id] > rq.priority_req) begin
                    id_pri[rq.id] = rq.priority_req;
                    bubble_down(rq.id);
                    rs.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (heap_count > 0) begin
                    top = slot_id[0];
                    rs.id_out = top;
                    rs.priority_out = id_pri[top];
                    id_live[top] = 1'b0;
                    heap_count--;
                    if (heap_count > 0) begin
                        put(0, slot_id[heap_count]);
                        bubble_down(slot_id[0]);
                    end
                    rs.ok = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (present) begin
                    rs.priority_out = id_pri[rq.id];
                    rs.ok = 1'b1;
                end
            end
            default: ;
        endcase
        rs.count = heap_count[6:0];
        return rs;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            heap_count = 0;
            fails = 0;
            rsp_queue.delete();
            for (int k = 0; k < 64; k++) id_live[k] = 1'b0;
        end else begin
            if (i_valid && o_ready) rsp_queue.push_back(apply_heap_op(i_req));
            if (o_valid && i_ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("unexpected result %p", o_rsp);
                    fails++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (o_rsp.ok !== want.ok) begin
                        $error("ok: expected %0d actual %0d", want.ok, o_rsp.ok);
                        fails++;
                    end
                    if (o_rsp.id_out !== want.id_out) begin
                        $error("id_out: expected %0d actual %0d", want.id_out, o_rsp.id_out);
                        fails++;
                    end
                    if (o_rsp.priority_out !== want.priority_out) begin
                        $error("priority_out: expected %0d actual %0d",
                               want.priority_out, o_rsp.priority_out);
                        fails++;
                    end
                    if (o_rsp.count !== want.count) begin
                        $error("count: expected %0d actual %0d", want.count, o_rsp.count);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/tb_indexed_max_heap_queue.sv -----
module tb_indexed_max_heap_queue;
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    indexed_max_heap_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    heap_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] cmd, logic [5:0] id, logic [31:0] pri);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= '{cmd: cmd, id: id, priority_req: pri};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_priority();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, int idle, int stall, int bias);
        int r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < bias) send_request(CMD_INSERT, 6'($urandom), pick_priority());
            else if (r < bias + 12) send_request(CMD_RAISE, 6'($urandom), pick_priority());
            else if (r < bias + 24) send_request(CMD_LOWER, 6'($urandom), pick_priority());
            else if (r < 90) send_request(CMD_REMOVE, 6'($urandom), $urandom);
            else if (r < 97) send_request(CMD_QUERY, 6'($urandom), $urandom);
            else send_request(3'($urandom_range(7, 5)), 6'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // empty heap rejects
        send_request(CMD_REMOVE, 6'd0, 32'd0);
        send_request(CMD_QUERY, 6'd5, 32'd0);
        send_request(CMD_RAISE, 6'd5, 32'h7fff_ffff);
        send_request(CMD_INSERT, 6'd63, 32'h8000_0000);
        send_request(CMD_INSERT, 6'd0, 32'h7fff_ffff);
        send_request(CMD_INSERT, 6'd0, 32'd1);
        send_request(CMD_INSERT, 6'd10, 32'h0001_0000);
        send_request(CMD_INSERT, 6'd11, 32'h0001_0000);
        send_request(CMD_INSERT, 6'd12, 32'h0001_0000);
        send_request(CMD_RAISE, 6'd10, 32'h0001_0000);
        send_request(CMD_LOWER, 6'd11, 32'h0001_0000);
        send_request(CMD_LOWER, 6'd0, 32'h8000_0000);
        send_request(CMD_RAISE, 6'd63, 32'h7fff_ffff);
        send_request(CMD_QUERY, 6'd63, 32'd0);
        send_request(3'd5, 6'd1, 32'd0);
        send_request(3'd7, 6'd63, 32'hffff_ffff);
        repeat (7) send_request(CMD_REMOVE, 6'd0, 32'd0);
        // fill to full then overflow
        for (int k = 0; k < 64; k++) send_request(CMD_INSERT, 6'(k), $urandom);
        send_request(CMD_INSERT, 6'd3, 32'd0);
        random_phase(300, 0, 0, 40);
        random_phase(300, 60, 0, 35);
        random_phase(300, 0, 60, 30);
        random_phase(300, 24, 24, 35);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
